@@ design/srrm_pkg.sv @@
// ----------------------------------------------------------------------------
// srrm_pkg
// Shared constants and codes for the sorted rectangle run merger.
// ----------------------------------------------------------------------------
package srrm_pkg;

  localparam int unsigned CoordBitsDefault = 16;

  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned TileSqW   = 2 * CfgDataW;
  localparam int unsigned TileReset = 16;
  localparam logic [TileSqW-1:0] TileSqReset = TileSqW'(TileReset * TileReset);

  typedef enum logic [0:0] {
    CfgMergeMode = 1'b0,
    CfgTileSize  = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    MergeDistance = 1'b0,
    MergeAdjacent = 1'b1
  } merge_mode_e;

endpackage

@@ design/srrm_if.sv @@
// ----------------------------------------------------------------------------
// srrm_if
// Valid/ready channels for incoming rectangles and merged rectangles.
// ----------------------------------------------------------------------------
interface srrm_rect_if #(
  parameter int unsigned CoordBits = srrm_pkg::CoordBitsDefault
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] rect_left;
  logic signed [CoordBits-1:0] rect_top;
  logic        [CoordBits-2:0] rect_width;
  logic        [CoordBits-2:0] rect_height;
  logic                        last_item;

  modport source (
    output valid, rect_left, rect_top, rect_width, rect_height, last_item,
    input  ready
  );
  modport sink (
    input  valid, rect_left, rect_top, rect_width, rect_height, last_item,
    output ready
  );
endinterface

interface srrm_merged_if #(
  parameter int unsigned CoordBits = srrm_pkg::CoordBitsDefault
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] out_left;
  logic signed [CoordBits-1:0] out_top;
  logic        [CoordBits-1:0] out_width;
  logic        [CoordBits-1:0] out_height;
  logic                        final_rect;

  modport source (
    output valid, out_left, out_top, out_width, out_height, final_rect,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_top, out_width, out_height, final_rect,
    output ready
  );
endinterface

@@ design/srrm_break_test.sv @@
// ----------------------------------------------------------------------------
// srrm_break_test
// Decides whether a new rectangle starts a new run: squared corner distance
// against the tile threshold, or overlap/touch with equal size.
// ----------------------------------------------------------------------------
module srrm_break_test #(
  parameter int unsigned CoordBits = srrm_pkg::CoordBitsDefault
) (
  input  srrm_pkg::merge_mode_e       mode_i,
  input  logic [srrm_pkg::TileSqW-1:0] tile_sq_i,
  input  logic signed [CoordBits:0]   p_left_i,
  input  logic signed [CoordBits:0]   p_top_i,
  input  logic signed [CoordBits:0]   p_right_i,
  input  logic signed [CoordBits:0]   p_bottom_i,
  input  logic signed [CoordBits:0]   r_left_i,
  input  logic signed [CoordBits:0]   r_top_i,
  input  logic signed [CoordBits:0]   r_right_i,
  input  logic signed [CoordBits:0]   r_bottom_i,
  output logic                        brk_o
);
  import srrm_pkg::*;

  localparam int unsigned SumW = (2 * CoordBits + 1 > TileSqW) ? 2 * CoordBits + 1 : TileSqW;

  logic signed [CoordBits:0]   dx;
  logic signed [CoordBits:0]   dy;
  logic        [CoordBits-1:0] mag_x;
  logic        [CoordBits-1:0] mag_y;
  logic        [2*CoordBits-1:0] sq_x;
  logic        [2*CoordBits-1:0] sq_y;
  logic        [SumW-1:0]      dist_sq;
  logic                        far;
  logic                        touch;
  logic                        same;

  always_comb begin
    dx    = r_left_i - p_left_i;
    dy    = r_top_i - p_top_i;
    mag_x = dx[CoordBits] ? CoordBits'(-dx) : CoordBits'(dx);
    mag_y = dy[CoordBits] ? CoordBits'(-dy) : CoordBits'(dy);
    sq_x  = (2 * CoordBits)'(mag_x) * (2 * CoordBits)'(mag_x);
    sq_y  = (2 * CoordBits)'(mag_y) * (2 * CoordBits)'(mag_y);
    dist_sq = SumW'(sq_x) + SumW'(sq_y);
    far   = dist_sq > SumW'(tile_sq_i);

    touch = (p_left_i <= r_right_i) && (r_left_i <= p_right_i) &&
            (p_top_i <= r_bottom_i) && (r_top_i <= p_bottom_i);
    same  = ((p_right_i - p_left_i) == (r_right_i - r_left_i)) &&
            ((p_bottom_i - p_top_i) == (r_bottom_i - r_top_i));

    case (mode_i)
      MergeDistance: brk_o = far;
      MergeAdjacent: brk_o = !(touch && same);
      default:       brk_o = far;
    endcase
  end

endmodule

@@ design/sorted_rect_run_merger.sv @@
// ----------------------------------------------------------------------------
// sorted_rect_run_merger
// Merges runs of consecutive sorted rectangles into grown rectangles and
// emits one on each run break and a final one on the last item of a pass.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  rect_i    | in  | valid/ready       | rect_left, rect_top, rect_width,
//            |     |                   | rect_height, last_item
//  merged_o  | out | valid/ready       | out_left, out_top, out_width,
//            |     |                   | out_height, final_rect
//  cfg       | in  | cfg_we_i          | cfg_idx_i, cfg_data_i
//
//  one rectangle per cycle while no results wait untaken; a rectangle that causes two
//  results (break plus final flush) holds the merge stage for two output transfers
//  path: accept -> input register -> merge stage -> result registers -> merged_o
//  the input register takes a new transfer while results wait in the result
//  registers; back pressure reaches rect_i.ready when the input register is full and its results cannot yet be taken
//  rst_ni clears valids, run state and config registers (mode distance, tile 16)
// ----------------------------------------------------------------------------
module sorted_rect_run_merger #(
  parameter int unsigned CoordBits = srrm_pkg::CoordBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  srrm_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [srrm_pkg::CfgDataW-1:0] cfg_data_i,
  srrm_rect_if.sink                     rect_i,
  srrm_merged_if.source                 merged_o
);
  import srrm_pkg::*;

  typedef struct packed {
    logic signed [CoordBits:0] left;
    logic signed [CoordBits:0] top;
    logic signed [CoordBits:0] right;
    logic signed [CoordBits:0] bottom;
  } rect_t;

  merge_mode_e          mode_q;
  logic [TileSqW-1:0]   tile_sq_q;

  logic                        s1_valid_q;
  logic signed [CoordBits-1:0] s1_left_q;
  logic signed [CoordBits-1:0] s1_top_q;
  logic        [CoordBits-2:0] s1_w_q;
  logic        [CoordBits-2:0] s1_h_q;
  logic                        s1_last_q;

  rect_t       grow_q;
  rect_t       prev_q;
  logic        have_grow_q;
  rect_t       res0_q;
  rect_t       res1_q;
  logic        res0_final_q;
  logic        res1_final_q;
  logic [1:0]  cnt_q;

  rect_t       cur;
  rect_t       uni;
  rect_t       grow_d;
  logic        brk_raw;
  logic        brk;
  logic        pop;
  logic        adv;
  logic        in_xfer;
  logic signed [CoordBits+1:0] span_w;
  logic signed [CoordBits+1:0] span_h;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MergeDistance;
      tile_sq_q <= TileSqReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMergeMode: mode_q    <= merge_mode_e'(cfg_data_i[0]);
        CfgTileSize:  tile_sq_q <= TileSqW'(cfg_data_i) * TileSqW'(cfg_data_i);
        default:      mode_q    <= mode_q;
      endcase
    end
  end

  // handshakes
  assign pop     = merged_o.valid && merged_o.ready;
  assign adv     = s1_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign rect_i.ready = !s1_valid_q || adv;
  assign in_xfer = rect_i.valid && rect_i.ready;

  // merge logic
  always_comb begin
    cur.left   = {s1_left_q[CoordBits-1], s1_left_q};
    cur.top    = {s1_top_q[CoordBits-1], s1_top_q};
    cur.right  = cur.left + $signed({2'b00, s1_w_q});
    cur.bottom = cur.top + $signed({2'b00, s1_h_q});

    uni.left   = (cur.left < grow_q.left) ? cur.left : grow_q.left;
    uni.top    = (cur.top < grow_q.top) ? cur.top : grow_q.top;
    uni.right  = (cur.right > grow_q.right) ? cur.right : grow_q.right;
    uni.bottom = (cur.bottom > grow_q.bottom) ? cur.bottom : grow_q.bottom;

    brk = have_grow_q && brk_raw;
    if (!have_grow_q || brk) begin
      grow_d = cur;
    end else begin
      grow_d = uni;
    end
  end

  srrm_break_test #(
    .CoordBits (CoordBits)
  ) u_break_test (
    .mode_i     (mode_q),
    .tile_sq_i  (tile_sq_q),
    .p_left_i   (prev_q.left),
    .p_top_i    (prev_q.top),
    .p_right_i  (prev_q.right),
    .p_bottom_i (prev_q.bottom),
    .r_left_i   (cur.left),
    .r_top_i    (cur.top),
    .r_right_i  (cur.right),
    .r_bottom_i (cur.bottom),
    .brk_o      (brk_raw)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      have_grow_q <= 1'b0;
      cnt_q       <= 2'd0;
      grow_q      <= '0;
      prev_q      <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end

      if (adv) begin
        grow_q      <= grow_d;
        prev_q      <= cur;
        have_grow_q <= !s1_last_q;
        cnt_q       <= {1'b0, brk} + {1'b0, s1_last_q};
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_left_q <= rect_i.rect_left;
      s1_top_q  <= rect_i.rect_top;
      s1_w_q    <= rect_i.rect_width;
      s1_h_q    <= rect_i.rect_height;
      s1_last_q <= rect_i.last_item;
    end

    if (adv) begin
      res0_q       <= brk ? grow_q : grow_d;
      res0_final_q <= !brk;
      res1_q       <= grow_d;
      res1_final_q <= 1'b1;
    end else if (pop) begin
      res0_q       <= res1_q;
      res0_final_q <= res1_final_q;
    end
  end

  // output formatting with saturation of the span
  always_comb begin
    span_w = {res0_q.right[CoordBits], res0_q.right} - {res0_q.left[CoordBits], res0_q.left};
    span_h = {res0_q.bottom[CoordBits], res0_q.bottom} - {res0_q.top[CoordBits], res0_q.top};
  end

  assign merged_o.valid      = (cnt_q != 2'd0);
  assign merged_o.out_left   = res0_q.left[CoordBits-1:0];
  assign merged_o.out_top    = res0_q.top[CoordBits-1:0];
  assign merged_o.out_width  = span_w[CoordBits] ? '1 : span_w[CoordBits-1:0];
  assign merged_o.out_height = span_h[CoordBits] ? '1 : span_h[CoordBits-1:0];
  assign merged_o.final_rect = res0_final_q;

  // checks
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q)
    else $error("input register dropped an item");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!res0_final_q && res1_final_q))
    else $error("break result must precede flush result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_last_q) |=> (!have_grow_q && merged_o.valid))
    else $error("last item did not flush the run");

  a_grow_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_grow_q |-> ((grow_q.right >= grow_q.left) && (grow_q.bottom >= grow_q.top)))
    else $error("grown rectangle has negative extent");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (cnt_q != 2'd3))
    else $error("result count overflow");

endmodule

@@ bench/sorted_rect_run_merger_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_rect_run_merger_tb
// Self-checking bench for the rectangle run merger. A directed table covers
// reset values, coordinate extremes, saturated unions and both break tests.
// Random passes of sorted rectangles with noise follow, under several register
// settings. Random gaps and stalls are applied on both channels. Every merged
// rectangle is compared field by field with a behavioral predictor.
// ----------------------------------------------------------------------------
module sorted_rect_run_merger_tb;
  import srrm_pkg::*;

  localparam int unsigned CW = CoordBitsDefault;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 6;
  localparam int DrainCycles = 40;
  localparam int PhaseItems = 195;
  localparam longint SizeMax = (longint'(1) << CW) - 1;

  typedef struct packed {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] top;
    logic [CW-2:0]        width;
    logic [CW-2:0]        height;
    logic                 last;
  } rect_t;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] width;
    logic [CW-1:0] height;
    logic          fin;
  } merged_t;

  typedef struct {
    longint l;
    longint t;
    longint r;
    longint b;
  } box_t;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    rect_t               rect;
    bit                  typed;
    int                  n_typed;
    merged_t             e0;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  srrm_rect_if #(.CoordBits(CW)) rect_ch ();
  srrm_merged_if #(.CoordBits(CW)) merged_ch ();

  sorted_rect_run_merger #(.CoordBits(CW)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rect_i     (rect_ch),
    .merged_o   (merged_ch)
  );

  merge_mode_e         mode_q = MergeDistance;
  logic [CfgDataW-1:0] tile_q = CfgDataW'(TileReset);
  box_t                grow_box;
  box_t                prev_box;
  bit                  growing = 1'b0;

  merged_t merged_exp_q[$];
  row_t    dir_rows[$];
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;
  bit      calm = 1'b0;
  int      cur_l;
  int      cur_t;
  int      run_w;
  int      run_h;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("sorted_rect_run_merger regression: fail");
      $finish;
    end
  end

  // stretches without any idling on either side
  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk_i);
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic int rand_size();
    int pick;
    pick = int'($urandom_range(0, 9));
    if (pick < 7) return int'($urandom_range(0, 32));
    if (pick < 9) return int'($urandom_range(0, 2047));
    return int'($urandom_range(0, 32767));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] got,
                             input logic [CW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic merged_t close_box(box_t b, bit fin);
    merged_t m;
    longint  w;
    longint  h;
    w = b.r - b.l;
    h = b.b - b.t;
    if (w > SizeMax) w = SizeMax;
    if (h > SizeMax) h = SizeMax;
    m.left   = CW'(b.l);
    m.top    = CW'(b.t);
    m.width  = CW'(w);
    m.height = CW'(h);
    m.fin    = fin;
    return m;
  endfunction

  function automatic bit run_breaks(box_t p, box_t r);
    longint dx;
    longint dy;
    longint ts;
    bit     touch;
    bit     same;
    if (mode_q == MergeDistance) begin
      dx = r.l - p.l;
      dy = r.t - p.t;
      ts = longint'(tile_q);
      return (dx * dx + dy * dy) > ts * ts;
    end
    touch = p.l <= r.r && r.l <= p.r && p.t <= r.b && r.t <= p.b;
    same  = (p.r - p.l) == (r.r - r.l) && (p.b - p.t) == (r.b - r.t);
    return !(touch && same);
  endfunction

  task automatic predict_merge(input rect_t rc, output merged_t o0, output merged_t o1,
                               output int n);
    box_t r;
    r.l = longint'(rc.left);
    r.t = longint'(rc.top);
    r.r = r.l + longint'(rc.width);
    r.b = r.t + longint'(rc.height);
    n  = 0;
    o0 = '0;
    o1 = '0;
    if (!growing) begin
      grow_box = r;
      growing  = 1'b1;
    end else if (run_breaks(prev_box, r)) begin
      o0 = close_box(grow_box, 1'b0);
      n = 1;
      grow_box = r;
    end else begin
      if (r.l < grow_box.l) grow_box.l = r.l;
      if (r.t < grow_box.t) grow_box.t = r.t;
      if (r.r > grow_box.r) grow_box.r = r.r;
      if (r.b > grow_box.b) grow_box.b = r.b;
    end
    prev_box = r;
    if (rc.last) begin
      if (n == 0) o0 = close_box(grow_box, 1'b1);
      else o1 = close_box(grow_box, 1'b1);
      n++;
      growing = 1'b0;
    end
  endtask

  task automatic send_rect(input rect_t rc, input bit typed, input int n_typed,
                           input merged_t t0);
    int      gap;
    int      n;
    merged_t p0;
    merged_t p1;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk_i);
      rect_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    rect_ch.valid       <= 1'b1;
    rect_ch.rect_left   <= rc.left;
    rect_ch.rect_top    <= rc.top;
    rect_ch.rect_width  <= rc.width;
    rect_ch.rect_height <= rc.height;
    rect_ch.last_item   <= rc.last;
    do @(posedge clk_i); while (rect_ch.ready !== 1'b1);
    predict_merge(rc, p0, p1, n);
    if (typed) begin
      n  = n_typed;
      p0 = t0;
    end
    if (n > 0) merged_exp_q.insert(merged_exp_q.size(), p0);
    if (n > 1) merged_exp_q.insert(merged_exp_q.size(), p1);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    rect_ch.valid <= 1'b0;
    while (merged_exp_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMergeMode) mode_q = merge_mode_e'(val[0]);
    else tile_q = val;
  endtask

  task automatic run_pass(input int len, inout int items);
    rect_t                rc;
    logic signed [CW-1:0] tmp;
    int                   kind;
    int                   dx;
    int                   dy;
    int                   span_x;
    int                   span_y;
    if ($urandom_range(0, 1)) begin
      cur_l = $urandom_range(0, 4000) - 2000;
      cur_t = $urandom_range(0, 4000) - 2000;
    end else begin
      tmp = CW'($urandom);
      cur_l = tmp;
      tmp = CW'($urandom);
      cur_t = tmp;
    end
    run_w = rand_size();
    run_h = rand_size();
    for (int k = 0; k < len; k++) begin
      kind = int'($urandom_range(0, 9));
      if (kind == 0) begin
        rc.left   = CW'($urandom);
        rc.top    = CW'($urandom);
        rc.width  = (CW-1)'($urandom);
        rc.height = (CW-1)'($urandom);
      end else begin
        if (kind == 1) begin
          run_w = rand_size();
          run_h = rand_size();
        end
        if (mode_q == MergeDistance) begin
          span_x = int'(tile_q) + 1;
          span_y = span_x;
        end else begin
          span_x = run_w + 1;
          span_y = run_h + 1;
        end
        dx = int'($urandom_range(0, 2 * span_x)) - span_x;
        dy = int'($urandom_range(0, 2 * span_y)) - span_y;
        rc.left   = CW'(cur_l + dx);
        rc.top    = CW'(cur_t + dy);
        rc.width  = (CW-1)'(run_w);
        rc.height = (CW-1)'(run_h);
        cur_l = rc.left;
        cur_t = rc.top;
      end
      rc.last = (k == len - 1);
      send_rect(rc, 1'b0, 0, '0);
      items++;
    end
  endtask

  function automatic void add_rect(int l, int t, int w, int h, bit last);
    row_t row;
    row.is_cfg  = 1'b0;
    row.idx     = CfgMergeMode;
    row.data    = '0;
    row.rect    = {CW'(l), CW'(t), (CW-1)'(w), (CW-1)'(h), last};
    row.typed   = 1'b0;
    row.n_typed = 0;
    row.e0      = '0;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_typed(int l, int t, int w, int h, bit last, int n, merged_t e0);
    add_rect(l, t, w, h, last);
    dir_rows[$].typed   = 1'b1;
    dir_rows[$].n_typed = n;
    dir_rows[$].e0      = e0;
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, int val);
    add_rect(0, 0, 0, 0, 1'b0);
    dir_rows[$].is_cfg = 1'b1;
    dir_rows[$].idx    = idx;
    dir_rows[$].data   = CfgDataW'(val);
  endfunction

  initial begin : merged_sink
    int      stall;
    merged_t got;
    merged_t want;
    merged_ch.ready = 1'b0;
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk_i);
        merged_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      merged_ch.ready <= 1'b1;
      do @(posedge clk_i); while (merged_ch.valid !== 1'b1);
      got.left   = merged_ch.out_left;
      got.top    = merged_ch.out_top;
      got.width  = merged_ch.out_width;
      got.height = merged_ch.out_height;
      got.fin    = merged_ch.final_rect;
      if (merged_exp_q.size() == 0) begin
        report_mismatch($sformatf("merged rect %0h with nothing pending", got));
      end else begin
        want = merged_exp_q.pop_front();
        check_field("out_left", got.left, want.left);
        check_field("out_top", got.top, want.top);
        check_field("out_width", got.width, want.width);
        check_field("out_height", got.height, want.height);
        check_field("final_rect", CW'(got.fin), CW'(want.fin));
      end
    end
  end

  initial begin : stimulus
    int                  items;
    logic                md;
    logic [CfgDataW-1:0] ts;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CfgMergeMode;
    cfg_data_i          = '0;
    rect_ch.valid       = 1'b0;
    rect_ch.rect_left   = '0;
    rect_ch.rect_top    = '0;
    rect_ch.rect_width  = '0;
    rect_ch.rect_height = '0;
    rect_ch.last_item   = 1'b0;

    // reset settings: distance test, tile 16
    add_typed(-32768, 32767, 32767, 0, 1'b1, 1,
              merged_t'{CW'(-32768), CW'(32767), CW'(32767), CW'(0), 1'b1});
    add_typed(0, 0, 0, 0, 1'b0, 0, '0);
    add_rect(16, 0, 5, 5, 1'b0);
    add_rect(16, 17, 5, 5, 1'b0);
    add_rect(20, 20, 0, 0, 1'b1);
    add_rect(100, 100, 1, 1, 1'b0);
    add_rect(32767, -32768, 32767, 32767, 1'b1);
    // zero tile: any moved corner breaks
    add_cfg(CfgTileSize, 0);
    add_rect(5, 5, 3, 3, 1'b0);
    add_rect(5, 5, 7, 7, 1'b0);
    add_rect(6, 5, 7, 7, 1'b1);
    // adjacency, union wider than the output range
    add_cfg(CfgMergeMode, MergeAdjacent);
    add_typed(-32768, -32768, 32767, 32767, 1'b0, 0, '0);
    add_typed(-1, -1, 32767, 32767, 1'b0, 0, '0);
    add_typed(32766, 32766, 32767, 32767, 1'b1, 1,
              merged_t'{CW'(-32768), CW'(-32768), CW'(65535), CW'(65535), 1'b1});
    add_rect(0, 0, 10, 10, 1'b0);
    add_rect(11, 0, 10, 10, 1'b0);
    add_rect(21, 0, 10, 10, 1'b0);
    add_rect(21, 10, 10, 9, 1'b1);
    add_rect(0, 0, 0, 0, 1'b0);
    add_rect(0, 0, 0, 0, 1'b1);
    // largest tile, threshold exactly on the edge then just past it
    add_cfg(CfgMergeMode, MergeDistance);
    add_cfg(CfgTileSize, 2047);
    add_rect(0, 0, 4, 4, 1'b0);
    add_rect(2047, 0, 4, 4, 1'b0);
    add_rect(-1, -1, 4, 4, 1'b1);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_rect(dir_rows[i].rect, dir_rows[i].typed, dir_rows[i].n_typed, dir_rows[i].e0);
    end

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin md = MergeDistance; ts = CfgDataW'(TileReset); end
        1: begin md = MergeDistance; ts = CfgDataW'(1); end
        2: begin md = MergeDistance; ts = CfgDataW'(1024); end
        3: begin md = MergeAdjacent; ts = CfgDataW'(TileReset); end
        4: begin md = MergeDistance; ts = CfgDataW'(0); end
        5: begin md = MergeAdjacent; ts = CfgDataW'(1024); end
        6: begin md = MergeDistance; ts = CfgDataW'(2047); end
        7: begin md = MergeDistance; ts = CfgDataW'($urandom_range(1, 1024)); end
        default: begin md = MergeAdjacent; ts = CfgDataW'($urandom_range(1, 1024)); end
      endcase
      write_reg(CfgMergeMode, CfgDataW'(md));
      write_reg(CfgTileSize, ts);
      items = 0;
      while (items < PhaseItems) run_pass(int'($urandom_range(1, 16)), items);
    end

    @(negedge clk_i);
    rect_ch.valid <= 1'b0;
    while (merged_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("sorted_rect_run_merger regression: pass");
    end else begin
      $display("sorted_rect_run_merger regression: fail");
    end
    $finish;
  end

endmodule
